[rtl/core/m6tp_pkg.sv]
// Shared types, constants and decode tables of the trace predecoder
package m6tp_pkg;

  localparam int unsigned TraceSlotsDef = 256;
  localparam int unsigned MaxUopsDef    = 32;

  localparam logic       OP_LOOKUP = 1'b0;
  localparam logic       OP_DECODE = 1'b1;
  localparam logic [5:0] KIND_NONE = 6'd34;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_NO_UOP  = 2'd1;
  localparam logic [1:0] ERR_NO_OPEN = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic capture;     // register the input transaction
    logic dir_read;    // read directory at captured address
    logic lookup_fin;  // finish lookup, drive result
    logic decode_fin;  // finish decode, drive result
    logic clear_done;  // clearing pass step
  } m6tp_cmd_t;

  // datapath status back to the controller
  typedef struct packed {
    logic op;
    logic clear_last;
  } m6tp_sts_t;

  // addressing mode of an opcode
  function automatic logic [4:0] mode_of(input logic [7:0] o);
    logic [4:0] m;
    m = 5'd0;
    unique case (o)
      8'h09, 8'h29, 8'h49, 8'h69, 8'h89, 8'ha9, 8'hc9, 8'he9,
      8'h0b, 8'h2b, 8'h4b, 8'h6b, 8'h8b, 8'hab, 8'hcb, 8'heb,
      8'h80, 8'ha0, 8'hc0, 8'he0, 8'h82, 8'ha2, 8'hc2, 8'he2,
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hb0, 8'hd0, 8'hf0: m = 5'd1;
      8'h0d, 8'h2d, 8'h4d, 8'h6d, 8'had, 8'hcd, 8'hed,
      8'h0e, 8'h2e, 8'h4e, 8'h6e, 8'hae, 8'hce, 8'hee,
      8'h0f, 8'h2f, 8'h4f, 8'h6f, 8'haf, 8'hcf, 8'hef,
      8'h0c, 8'h2c, 8'hac, 8'hcc, 8'hec: m = 5'd2;
      8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h4c, 8'h20: m = 5'd3;
      8'h6c: m = 5'd4;
      8'h1c, 8'h3c, 8'h5c, 8'h7c, 8'h9c, 8'hbc, 8'hdc, 8'hfc,
      8'h1d, 8'h3d, 8'h5d, 8'h7d, 8'hbd, 8'hdd, 8'hfd,
      8'h1e, 8'h3e, 8'h5e, 8'h7e, 8'hde, 8'hfe,
      8'h1f, 8'h3f, 8'h5f, 8'h7f, 8'hdf, 8'hff: m = 5'd5;
      8'h9d: m = 5'd6;
      8'h19, 8'h39, 8'h59, 8'h79, 8'hb9, 8'hd9, 8'hf9,
      8'h1b, 8'h3b, 8'h5b, 8'h7b, 8'h9b, 8'hbb, 8'hdb, 8'hfb,
      8'h9e, 8'hbe, 8'h9f, 8'hbf: m = 5'd7;
      8'h99: m = 5'd8;
      8'h04, 8'h24, 8'h44, 8'h64, 8'ha4, 8'hc4, 8'he4,
      8'h05, 8'h25, 8'h45, 8'h65, 8'ha5, 8'hc5, 8'he5,
      8'h06, 8'h26, 8'h46, 8'h66, 8'ha6, 8'hc6, 8'he6,
      8'h07, 8'h27, 8'h47, 8'h67, 8'ha7, 8'hc7, 8'he7: m = 5'd9;
      8'h84, 8'h85, 8'h86, 8'h87: m = 5'd10;
      8'h14, 8'h34, 8'h54, 8'h74, 8'hb4, 8'hd4, 8'hf4,
      8'h15, 8'h35, 8'h55, 8'h75, 8'hb5, 8'hd5, 8'hf5,
      8'h16, 8'h36, 8'h56, 8'h76, 8'hd6, 8'hf6,
      8'h17, 8'h37, 8'h57, 8'h77, 8'hd7, 8'hf7: m = 5'd11;
      8'h94, 8'h95: m = 5'd12;
      8'hb6, 8'hb7: m = 5'd13;
      8'h96, 8'h97: m = 5'd14;
      8'h01, 8'h21, 8'h41, 8'h61, 8'ha1, 8'hc1, 8'he1,
      8'h03, 8'h23, 8'h43, 8'h63, 8'ha3, 8'hc3, 8'he3: m = 5'd15;
      8'h81, 8'h83: m = 5'd16;
      8'h11, 8'h31, 8'h51, 8'h71, 8'hb1, 8'hd1, 8'hf1,
      8'h13, 8'h33, 8'h53, 8'h73, 8'hb3, 8'hd3, 8'hf3: m = 5'd17;
      8'h91, 8'h93: m = 5'd18;
      default: m = 5'd0;
    endcase
    return m;
  endfunction

  // uop kind in the upper bits, data byte in the lower eight
  function automatic logic [13:0] kind_of(input logic [7:0] o);
    logic [5:0] k;
    logic [7:0] d;
    d = 8'h00;
    k = KIND_NONE;
    unique case (o)
      8'h18: begin k = 6'd0; d = 8'h01; end
      8'h58: begin k = 6'd0; d = 8'h04; end
      8'hb8: begin k = 6'd0; d = 8'h40; end
      8'hd8: begin k = 6'd0; d = 8'h08; end
      8'h38: begin k = 6'd1; d = 8'h01; end
      8'h78: begin k = 6'd1; d = 8'h04; end
      8'hf8: begin k = 6'd1; d = 8'h08; end
      8'haa: begin k = 6'd2; d = 8'h04; end
      8'ha8: begin k = 6'd2; d = 8'h08; end
      8'hba: begin k = 6'd3; d = 8'h07; end
      8'h8a: begin k = 6'd2; d = 8'h01; end
      8'h9a: begin k = 6'd2; d = 8'h0d; end
      8'h98: begin k = 6'd2; d = 8'h02; end
      8'ha1, 8'ha5, 8'ha9, 8'had, 8'hb1, 8'hb5, 8'hb9, 8'hbd: k = 6'd4;
      8'ha2, 8'ha6, 8'hae, 8'hb6, 8'hbe: begin k = 6'd4; d = 8'h01; end
      8'ha0, 8'ha4, 8'hac, 8'hb4, 8'hbc: begin k = 6'd4; d = 8'h02; end
      8'h81, 8'h85, 8'h89, 8'h8d, 8'h91, 8'h95, 8'h99, 8'h9d: k = 6'd5;
      8'h86, 8'h8e, 8'h96: begin k = 6'd5; d = 8'h01; end
      8'h84, 8'h8c, 8'h94: begin k = 6'd5; d = 8'h02; end
      8'hc1, 8'hc5, 8'hc9, 8'hcd, 8'hd1, 8'hd5, 8'hd9, 8'hdd: k = 6'd6;
      8'he0, 8'he4, 8'hec: begin k = 6'd6; d = 8'h01; end
      8'hc0, 8'hc4, 8'hcc: begin k = 6'd6; d = 8'h02; end
      8'he6, 8'hee, 8'hf6, 8'hfe: k = 6'd7;
      8'hc6, 8'hce, 8'hd6, 8'hde: begin k = 6'd7; d = 8'h80; end
      8'he8: begin k = 6'd8; d = 8'h01; end
      8'hc8: begin k = 6'd8; d = 8'h02; end
      8'hca: begin k = 6'd8; d = 8'h81; end
      8'h88: begin k = 6'd8; d = 8'h82; end
      8'h24, 8'h2c: k = 6'd9;
      8'h10: begin k = 6'd10; d = 8'h80; end
      8'h50: begin k = 6'd10; d = 8'h40; end
      8'h90: begin k = 6'd10; d = 8'h01; end
      8'hd0: begin k = 6'd10; d = 8'h02; end
      8'h30: begin k = 6'd11; d = 8'h80; end
      8'h70: begin k = 6'd11; d = 8'h40; end
      8'hb0: begin k = 6'd11; d = 8'h01; end
      8'hf0: begin k = 6'd11; d = 8'h02; end
      8'h4c, 8'h6c: k = 6'd12;
      8'h20: k = 6'd13;
      8'h60: k = 6'd14;
      8'h40: k = 6'd15;
      8'h00: k = 6'd16;
      8'h01, 8'h05, 8'h09, 8'h0d, 8'h11, 8'h15, 8'h19, 8'h1d: k = 6'd17;
      8'h21, 8'h25, 8'h29, 8'h2d, 8'h31, 8'h35, 8'h39, 8'h3d: k = 6'd18;
      8'h41, 8'h45, 8'h49, 8'h4d, 8'h51, 8'h55, 8'h59, 8'h5d: k = 6'd19;
      8'h61, 8'h65, 8'h69, 8'h6d, 8'h71, 8'h75, 8'h79, 8'h7d: k = 6'd20;
      8'he1, 8'he5, 8'he9, 8'hed, 8'hf1, 8'hf5, 8'hf9, 8'hfd: begin
        k = 6'd20; d = 8'hff;
      end
      8'h06, 8'h0e, 8'h16, 8'h1e: k = 6'd21;
      8'h0a: k = 6'd22;
      8'h26, 8'h2e, 8'h36, 8'h3e: k = 6'd23;
      8'h2a: k = 6'd24;
      8'h46, 8'h4e, 8'h56, 8'h5e: k = 6'd25;
      8'h4a: k = 6'd26;
      8'h66, 8'h6e, 8'h76, 8'h7e: k = 6'd27;
      8'h6a: k = 6'd28;
      8'h48: k = 6'd29;
      8'h08: k = 6'd30;
      8'h68: k = 6'd31;
      8'h28: k = 6'd32;
      8'hea: k = 6'd33;
      default: begin k = KIND_NONE; d = 8'h00; end
    endcase
    return {k, d};
  endfunction

endpackage

[rtl/core/m6tp_ctrl.sv]
// Sequencer of the trace predecoder: clearing pass, lookup and decode steps
module m6tp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output m6tp_pkg::m6tp_cmd_t cmd,
  input  m6tp_pkg::m6tp_sts_t sts
);
  import m6tp_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_LOOK, S_DEC} state_t;
  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clear_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_READ;
      S_READ:  state_nxt = (sts.op == OP_DECODE) ? S_DEC : S_LOOK;
      S_LOOK:  state_nxt = S_IDLE;
      S_DEC:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.clear_done = (state_r == S_CLEAR);
    cmd.capture    = (state_r == S_IDLE) && start;
    cmd.dir_read   = (state_r == S_READ);
    cmd.lookup_fin = (state_r == S_LOOK);
    cmd.decode_fin = (state_r == S_DEC);
  end

  assign busy = (state_r != S_IDLE);

endmodule

[rtl/core/m6tp_dp.sv]
// Datapath: directory memory, slot tables, build state and decode
module m6tp_dp #(
  parameter int unsigned TRACE_SLOTS = m6tp_pkg::TraceSlotsDef,
  parameter int unsigned MAX_UOPS    = m6tp_pkg::MaxUopsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  m6tp_pkg::m6tp_cmd_t cmd,
  output m6tp_pkg::m6tp_sts_t sts,
  input  logic              in_op,
  input  logic [15:0]       in_address,
  input  logic [7:0]        in_opcode,
  input  logic [7:0]        in_operand_low,
  input  logic [7:0]        in_operand_high,
  output logic              out_valid,
  output logic              out_hit,
  output logic [7:0]        out_slot,
  output logic [5:0]        out_uop_kind,
  output logic [4:0]        out_addr_mode,
  output logic [1:0]        out_instr_length,
  output logic [15:0]       out_operand_address,
  output logic [7:0]        out_uop_data,
  output logic              out_last_uop,
  output logic [1:0]        out_error
);
  import m6tp_pkg::*;

  localparam int unsigned SW = (TRACE_SLOTS > 1) ? $clog2(TRACE_SLOTS) : 1;
  localparam int unsigned DW = SW + 1;
  localparam int unsigned CW = $clog2(MAX_UOPS + 1);

  // directory holds slot+1, zero invalid; cleared by a pass after reset
  logic [DW-1:0] dir_mem [65536];
  logic [15:0]   start_mem [TRACE_SLOTS];
  logic [CW-1:0] cnt_mem [TRACE_SLOTS];

  logic [15:0]   clr_r;
  logic          op_r;
  logic [15:0]   addr_r;
  logic [7:0]    opc_r, lo_r, hi_r;
  logic [DW-1:0] dir_q_r;
  logic [15:0]   old_start_r;
  logic [CW-1:0] old_cnt_r;
  logic [CW-1:0] cur_cnt_r;
  logic [SW-1:0] cursor_r, build_slot_r;
  logic          open_r;

  assign sts.op         = op_r;
  assign sts.clear_last = (clr_r == 16'hffff);

  // capture and first read cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      addr_r <= in_address;
      opc_r  <= in_opcode;
      lo_r   <= in_operand_low;
      hi_r   <= in_operand_high;
    end
    if (cmd.dir_read) begin
      dir_q_r     <= dir_mem[addr_r];
      old_start_r <= start_mem[cursor_r];
      old_cnt_r   <= cnt_mem[cursor_r];
      cur_cnt_r   <= cnt_mem[build_slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clear_done) clr_r <= clr_r + 16'd1;
  end

  // decode combinational
  logic [4:0]    mode;
  logic [13:0]   kd;
  logic [1:0]    len;
  logic [CW:0]   cnt_inc;
  logic          last;
  assign mode    = mode_of(opc_r);
  assign kd      = kind_of(opc_r);
  assign len     = (mode == 5'd0) ? 2'd1 : ((mode >= 5'd2 && mode <= 5'd8) ? 2'd3 : 2'd2);
  assign cnt_inc = {1'b0, cur_cnt_r} + {{CW{1'b0}}, 1'b1};
  assign last    = (kd[13:8] >= 6'd10 && kd[13:8] <= 6'd16) ||
                   (cnt_inc >= (CW+1)'(MAX_UOPS));

  logic miss;
  assign miss = (dir_q_r == '0);

  // invalidate old owner's address: done the cycle after a miss allocation
  logic          inval_r;
  logic [15:0]   inval_addr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) inval_r <= 1'b0;
    else inval_r <= cmd.lookup_fin && miss && (old_cnt_r != '0) &&
                    (old_start_r != addr_r);
    inval_addr_r <= old_start_r;
  end

  // directory and slot table writes
  always_ff @(posedge clk) begin
    if (cmd.clear_done) dir_mem[clr_r] <= '0;
    else if (cmd.lookup_fin && miss) dir_mem[addr_r] <= DW'(cursor_r) + DW'(1);
    else if (inval_r) dir_mem[inval_addr_r] <= '0;
    if (cmd.lookup_fin && miss) start_mem[cursor_r] <= addr_r;
  end

  // uop counts: reset state through the clearing pass index
  always_ff @(posedge clk) begin
    if (cmd.clear_done) cnt_mem[clr_r[SW-1:0]] <= '0;
    else if (cmd.lookup_fin && miss) cnt_mem[cursor_r] <= '0;
    else if (cmd.decode_fin && open_r) cnt_mem[build_slot_r] <= cnt_inc[CW-1:0];
  end

  // build state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r     <= '0;
      build_slot_r <= '0;
      open_r       <= 1'b0;
    end else if (cmd.lookup_fin) begin
      open_r <= miss;
      if (miss) begin
        build_slot_r <= cursor_r;
        cursor_r     <= (cursor_r == SW'(TRACE_SLOTS - 1)) ? '0 : cursor_r + SW'(1);
      end
    end else if (cmd.decode_fin && open_r && last) begin
      open_r <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= cmd.lookup_fin || cmd.decode_fin;
    out_hit             <= 1'b0;
    out_slot            <= '0;
    out_uop_kind        <= KIND_NONE;
    out_addr_mode       <= '0;
    out_instr_length    <= '0;
    out_operand_address <= '0;
    out_uop_data        <= '0;
    out_last_uop        <= 1'b0;
    out_error           <= ERR_OK;
    if (cmd.lookup_fin) begin
      out_hit  <= !miss;
      out_slot <= miss ? 8'(cursor_r) : 8'(dir_q_r - DW'(1));
    end else if (cmd.decode_fin) begin
      if (!open_r) begin
        out_error <= ERR_NO_OPEN;
      end else begin
        out_slot         <= 8'(build_slot_r);
        out_uop_kind     <= kd[13:8];
        out_addr_mode    <= mode;
        out_instr_length <= len;
        out_operand_address <= (len == 2'd1) ? 16'h0000 :
                               ((len == 2'd2) ? {8'h00, lo_r} : {hi_r, lo_r});
        out_uop_data     <= kd[7:0];
        out_last_uop     <= last;
        out_error        <= (kd[13:8] == KIND_NONE) ? ERR_NO_UOP : ERR_OK;
      end
    end
  end

endmodule

[rtl/core/mos6502_trace_predecoder.sv]
// Top level of the trace predecoder
// Channel | ports                      | handshake
// input   | in_op..in_operand_high     | start high while busy low
// result  | out_hit..out_error         | out_valid for one cycle, no stall
// An item passes through capture, directory/slot table read and finish.
// A miss whose victim slot holds uops clears the victim's old directory entry in the cycle after finish.
// After reset a clearing pass wipes every directory entry; busy is high.
// One result per item; the receiver cannot stall.
module mos6502_trace_predecoder #(
  parameter int unsigned TRACE_SLOTS = m6tp_pkg::TraceSlotsDef,
  parameter int unsigned MAX_UOPS    = m6tp_pkg::MaxUopsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_operand_low,
  input  logic [7:0]  in_operand_high,
  output logic        out_valid,
  output logic        out_hit,
  output logic [7:0]  out_slot,
  output logic [5:0]  out_uop_kind,
  output logic [4:0]  out_addr_mode,
  output logic [1:0]  out_instr_length,
  output logic [15:0] out_operand_address,
  output logic [7:0]  out_uop_data,
  output logic        out_last_uop,
  output logic [1:0]  out_error
);
  import m6tp_pkg::*;

  m6tp_cmd_t cmd;
  m6tp_sts_t sts;

  m6tp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  m6tp_dp #(.TRACE_SLOTS(TRACE_SLOTS), .MAX_UOPS(MAX_UOPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_op), .in_address(in_address), .in_opcode(in_opcode),
    .in_operand_low(in_operand_low), .in_operand_high(in_operand_high),
    .out_valid(out_valid), .out_hit(out_hit), .out_slot(out_slot),
    .out_uop_kind(out_uop_kind), .out_addr_mode(out_addr_mode),
    .out_instr_length(out_instr_length), .out_operand_address(out_operand_address),
    .out_uop_data(out_uop_data), .out_last_uop(out_last_uop), .out_error(out_error)
  );

endmodule

[tb/mos6502_trace_predecoder_checker.sv]
// Checker of the trace predecoder: predicts every result and compares it
`timescale 1ns / 1ps

module mos6502_trace_predecoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_op,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_operand_low,
  input  logic [7:0]  in_operand_high,
  input  logic        out_valid,
  input  logic        out_hit,
  input  logic [7:0]  out_slot,
  input  logic [5:0]  out_uop_kind,
  input  logic [4:0]  out_addr_mode,
  input  logic [1:0]  out_instr_length,
  input  logic [15:0] out_operand_address,
  input  logic [7:0]  out_uop_data,
  input  logic        out_last_uop,
  input  logic [1:0]  out_error,
  output int          fails,
  output int          pending,
  output int          hit_count,
  output int          close_count
);
  import m6tp_pkg::*;

  localparam int SLOTS   = 256;
  localparam int UOP_MAX = 32;

  typedef enum logic [5:0] {
    K_P_UNSET, K_P_SET, K_MOV, K_MOV_NOFLAG, K_LOAD, K_STORE, K_CMP, K_ADD_MEM,
    K_ADD_REG, K_TEST, K_BRANCH_UNSET, K_BRANCH_SET, K_JMP, K_JSR, K_RTS, K_RTI,
    K_BRK, K_ORA, K_AND, K_EOR, K_ADC, K_ASL, K_ASL_REG, K_ROL, K_ROL_REG, K_LSR,
    K_LSR_REG, K_ROR, K_ROR_REG, K_PUSHA, K_PUSHP, K_POPA, K_POPP, K_NOP, K_NONE
  } uop_kind_e;

  typedef enum logic [4:0] {
    AM_NONE, AM_IMM, AM_ABS, AM_ABS_NR, AM_IND_NR, AM_ABSX, AM_ABSX_NR, AM_ABSY,
    AM_ABSY_NR, AM_ZP, AM_ZP_NR, AM_ZPX, AM_ZPX_NR, AM_ZPY, AM_ZPY_NR, AM_IZX,
    AM_IZX_NR, AM_IZY, AM_IZY_NR
  } amode_e;

  localparam logic [7:0] REG_A = 8'd0, REG_X = 8'd1, REG_Y = 8'd2, REG_S = 8'd3;

  typedef struct packed {
    logic        hit;
    logic [7:0]  slot;
    logic [5:0]  kind;
    logic [4:0]  mode;
    logic [1:0]  len;
    logic [15:0] oper;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  err;
  } uop_res_t;

  // predictor state
  logic [8:0]  dir_map [65536];    // slot + 1, zero when invalid
  logic [15:0] slot_base [SLOTS];
  logic [6:0]  slot_fill [SLOTS];
  logic [7:0]  cursor;
  logic [7:0]  build_at;
  logic        build_live;

  uop_res_t outstanding [$];

  function automatic amode_e amode_of(input logic [7:0] o);
    case (o)
      8'h09, 8'h29, 8'h49, 8'h69, 8'h89, 8'ha9, 8'hc9, 8'he9,
      8'h0b, 8'h2b, 8'h4b, 8'h6b, 8'h8b, 8'hab, 8'hcb, 8'heb,
      8'h80, 8'ha0, 8'hc0, 8'he0, 8'h82, 8'ha2, 8'hc2, 8'he2,
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hb0, 8'hd0, 8'hf0: return AM_IMM;
      8'h0d, 8'h2d, 8'h4d, 8'h6d, 8'had, 8'hcd, 8'hed,
      8'h0e, 8'h2e, 8'h4e, 8'h6e, 8'hae, 8'hce, 8'hee,
      8'h0f, 8'h2f, 8'h4f, 8'h6f, 8'haf, 8'hcf, 8'hef,
      8'h0c, 8'h2c, 8'hac, 8'hcc, 8'hec: return AM_ABS;
      8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h4c, 8'h20: return AM_ABS_NR;
      8'h6c: return AM_IND_NR;
      8'h1c, 8'h3c, 8'h5c, 8'h7c, 8'h9c, 8'hbc, 8'hdc, 8'hfc,
      8'h1d, 8'h3d, 8'h5d, 8'h7d, 8'hbd, 8'hdd, 8'hfd,
      8'h1e, 8'h3e, 8'h5e, 8'h7e, 8'hde, 8'hfe,
      8'h1f, 8'h3f, 8'h5f, 8'h7f, 8'hdf, 8'hff: return AM_ABSX;
      8'h9d: return AM_ABSX_NR;
      8'h19, 8'h39, 8'h59, 8'h79, 8'hb9, 8'hd9, 8'hf9,
      8'h1b, 8'h3b, 8'h5b, 8'h7b, 8'h9b, 8'hbb, 8'hdb, 8'hfb,
      8'h9e, 8'hbe, 8'h9f, 8'hbf: return AM_ABSY;
      8'h99: return AM_ABSY_NR;
      8'h04, 8'h24, 8'h44, 8'h64, 8'ha4, 8'hc4, 8'he4,
      8'h05, 8'h25, 8'h45, 8'h65, 8'ha5, 8'hc5, 8'he5,
      8'h06, 8'h26, 8'h46, 8'h66, 8'ha6, 8'hc6, 8'he6,
      8'h07, 8'h27, 8'h47, 8'h67, 8'ha7, 8'hc7, 8'he7: return AM_ZP;
      8'h84, 8'h85, 8'h86, 8'h87: return AM_ZP_NR;
      8'h14, 8'h34, 8'h54, 8'h74, 8'hb4, 8'hd4, 8'hf4,
      8'h15, 8'h35, 8'h55, 8'h75, 8'hb5, 8'hd5, 8'hf5,
      8'h16, 8'h36, 8'h56, 8'h76, 8'hd6, 8'hf6,
      8'h17, 8'h37, 8'h57, 8'h77, 8'hd7, 8'hf7: return AM_ZPX;
      8'h94, 8'h95: return AM_ZPX_NR;
      8'hb6, 8'hb7: return AM_ZPY;
      8'h96, 8'h97: return AM_ZPY_NR;
      8'h01, 8'h21, 8'h41, 8'h61, 8'ha1, 8'hc1, 8'he1,
      8'h03, 8'h23, 8'h43, 8'h63, 8'ha3, 8'hc3, 8'he3: return AM_IZX;
      8'h81, 8'h83: return AM_IZX_NR;
      8'h11, 8'h31, 8'h51, 8'h71, 8'hb1, 8'hd1, 8'hf1,
      8'h13, 8'h33, 8'h53, 8'h73, 8'hb3, 8'hd3, 8'hf3: return AM_IZY;
      8'h91, 8'h93: return AM_IZY_NR;
      default: return AM_NONE;
    endcase
  endfunction

  // register pair of a transfer: source in the low bits, destination above
  function automatic logic [7:0] reg_pair(input logic [7:0] src, input logic [7:0] dst);
    return {dst[5:0], src[1:0]};
  endfunction

  function automatic void uop_of(input logic [7:0] o, output uop_kind_e k,
                                 output logic [7:0] d);
    d = 8'h00;
    k = K_NONE;
    case (o)
      8'h18: begin k = K_P_UNSET; d = 8'h01; end
      8'h58: begin k = K_P_UNSET; d = 8'h04; end
      8'hb8: begin k = K_P_UNSET; d = 8'h40; end
      8'hd8: begin k = K_P_UNSET; d = 8'h08; end
      8'h38: begin k = K_P_SET; d = 8'h01; end
      8'h78: begin k = K_P_SET; d = 8'h04; end
      8'hf8: begin k = K_P_SET; d = 8'h08; end
      8'haa: begin k = K_MOV; d = reg_pair(REG_A, REG_X); end
      8'ha8: begin k = K_MOV; d = reg_pair(REG_A, REG_Y); end
      8'hba: begin k = K_MOV_NOFLAG; d = reg_pair(REG_S, REG_X); end
      8'h8a: begin k = K_MOV; d = reg_pair(REG_X, REG_A); end
      8'h9a: begin k = K_MOV; d = reg_pair(REG_X, REG_S); end
      8'h98: begin k = K_MOV; d = reg_pair(REG_Y, REG_A); end
      8'ha1, 8'ha5, 8'ha9, 8'had, 8'hb1, 8'hb5, 8'hb9, 8'hbd: k = K_LOAD;
      8'ha2, 8'ha6, 8'hae, 8'hb6, 8'hbe: begin k = K_LOAD; d = REG_X; end
      8'ha0, 8'ha4, 8'hac, 8'hb4, 8'hbc: begin k = K_LOAD; d = REG_Y; end
      8'h81, 8'h85, 8'h89, 8'h8d, 8'h91, 8'h95, 8'h99, 8'h9d: k = K_STORE;
      8'h86, 8'h8e, 8'h96: begin k = K_STORE; d = REG_X; end
      8'h84, 8'h8c, 8'h94: begin k = K_STORE; d = REG_Y; end
      8'hc1, 8'hc5, 8'hc9, 8'hcd, 8'hd1, 8'hd5, 8'hd9, 8'hdd: k = K_CMP;
      8'he0, 8'he4, 8'hec: begin k = K_CMP; d = REG_X; end
      8'hc0, 8'hc4, 8'hcc: begin k = K_CMP; d = REG_Y; end
      8'he6, 8'hee, 8'hf6, 8'hfe: k = K_ADD_MEM;
      8'hc6, 8'hce, 8'hd6, 8'hde: begin k = K_ADD_MEM; d = 8'h80; end
      8'he8: begin k = K_ADD_REG; d = REG_X; end
      8'hc8: begin k = K_ADD_REG; d = REG_Y; end
      8'hca: begin k = K_ADD_REG; d = 8'h80 | REG_X; end
      8'h88: begin k = K_ADD_REG; d = 8'h80 | REG_Y; end
      8'h24, 8'h2c: k = K_TEST;
      8'h10: begin k = K_BRANCH_UNSET; d = 8'h80; end
      8'h50: begin k = K_BRANCH_UNSET; d = 8'h40; end
      8'h90: begin k = K_BRANCH_UNSET; d = 8'h01; end
      8'hd0: begin k = K_BRANCH_UNSET; d = 8'h02; end
      8'h30: begin k = K_BRANCH_SET; d = 8'h80; end
      8'h70: begin k = K_BRANCH_SET; d = 8'h40; end
      8'hb0: begin k = K_BRANCH_SET; d = 8'h01; end
      8'hf0: begin k = K_BRANCH_SET; d = 8'h02; end
      8'h4c, 8'h6c: k = K_JMP;
      8'h20: k = K_JSR;
      8'h60: k = K_RTS;
      8'h40: k = K_RTI;
      8'h00: k = K_BRK;
      8'h01, 8'h05, 8'h09, 8'h0d, 8'h11, 8'h15, 8'h19, 8'h1d: k = K_ORA;
      8'h21, 8'h25, 8'h29, 8'h2d, 8'h31, 8'h35, 8'h39, 8'h3d: k = K_AND;
      8'h41, 8'h45, 8'h49, 8'h4d, 8'h51, 8'h55, 8'h59, 8'h5d: k = K_EOR;
      8'h61, 8'h65, 8'h69, 8'h6d, 8'h71, 8'h75, 8'h79, 8'h7d: k = K_ADC;
      8'he1, 8'he5, 8'he9, 8'hed, 8'hf1, 8'hf5, 8'hf9, 8'hfd: begin
        k = K_ADC; d = 8'hff;
      end
      8'h06, 8'h0e, 8'h16, 8'h1e: k = K_ASL;
      8'h0a: k = K_ASL_REG;
      8'h26, 8'h2e, 8'h36, 8'h3e: k = K_ROL;
      8'h2a: k = K_ROL_REG;
      8'h46, 8'h4e, 8'h56, 8'h5e: k = K_LSR;
      8'h4a: k = K_LSR_REG;
      8'h66, 8'h6e, 8'h76, 8'h7e: k = K_ROR;
      8'h6a: k = K_ROR_REG;
      8'h48: k = K_PUSHA;
      8'h08: k = K_PUSHP;
      8'h68: k = K_POPA;
      8'h28: k = K_POPP;
      8'hea: k = K_NOP;
      default: k = K_NONE;
    endcase
  endfunction

  // advance the predictor by one accepted transaction
  function automatic uop_res_t trace_step(input logic op, input logic [15:0] addr,
                                         input logic [7:0] opc, input logic [7:0] lo,
                                         input logic [7:0] hi);
    uop_res_t  r;
    uop_kind_e k;
    logic [7:0] d;
    amode_e    m;
    logic [6:0] n;
    r = '0;
    r.kind = K_NONE;
    if (op == OP_LOOKUP) begin
      build_live = 1'b0;
      if (dir_map[addr] != 9'd0) begin
        r.hit  = 1'b1;
        r.slot = 8'(dir_map[addr] - 9'd1);
      end else begin
        // round-robin victim; only a slot holding uops drops its old entry
        if (slot_fill[cursor] != 7'd0) dir_map[slot_base[cursor]] = 9'd0;
        slot_fill[cursor] = 7'd0;
        slot_base[cursor] = addr;
        dir_map[addr]     = {1'b0, cursor} + 9'd1;
        build_at   = cursor;
        build_live = 1'b1;
        r.slot     = cursor;
        cursor     = cursor + 8'd1;
      end
    end else if (!build_live) begin
      r.err = ERR_NO_OPEN;
    end else begin
      m = amode_of(opc);
      uop_of(opc, k, d);
      n = slot_fill[build_at] + 7'd1;
      slot_fill[build_at] = n;
      r.slot = build_at;
      r.kind = k;
      r.mode = m;
      r.len  = (m == AM_NONE) ? 2'd1 : ((m >= AM_ABS && m <= AM_ABSY_NR) ? 2'd3 : 2'd2);
      r.oper = (r.len == 2'd1) ? 16'd0 : ((r.len == 2'd2) ? {8'd0, lo} : {hi, lo});
      r.data = d;
      r.last = (k >= K_BRANCH_UNSET && k <= K_BRK) || n >= UOP_MAX;
      r.err  = (k == K_NONE) ? ERR_NO_UOP : ERR_OK;
      if (r.last) build_live = 1'b0;
    end
    return r;
  endfunction

  function automatic int field_bad(input string name, input int want, input int got);
    if (want == got) return 0;
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  // compare results first, then take in the transaction of this edge
  always @(posedge clk) begin
    uop_res_t w;
    int bad;
    if (!rst_n) begin
      for (int i = 0; i < 65536; i++) dir_map[i] = 9'd0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_base[i] = 16'd0;
        slot_fill[i] = 7'd0;
      end
      cursor      = 8'd0;
      build_at    = 8'd0;
      build_live  = 1'b0;
      fails       = 0;
      hit_count   = 0;
      close_count = 0;
      outstanding.delete();
    end else begin
      if (out_valid) begin
        if (outstanding.size() == 0) begin
          $display("%0t: result with nothing expected (slot %0d, kind %0d)",
                   $time, out_slot, out_uop_kind);
          fails++;
        end else begin
          w = outstanding.pop_front();
          bad = field_bad("hit", w.hit, out_hit)
              + field_bad("slot", w.slot, out_slot)
              + field_bad("uop_kind", w.kind, out_uop_kind)
              + field_bad("addr_mode", w.mode, out_addr_mode)
              + field_bad("instr_length", w.len, out_instr_length)
              + field_bad("operand_address", w.oper, out_operand_address)
              + field_bad("uop_data", w.data, out_uop_data)
              + field_bad("last_uop", w.last, out_last_uop)
              + field_bad("error", w.err, out_error);
          if (bad != 0) fails++;
          if (w.hit) hit_count++;
          if (w.last) close_count++;
        end
      end
      if (start && !busy)
        outstanding.push_back(trace_step(in_op, in_address, in_opcode,
                                         in_operand_low, in_operand_high));
    end
    pending = outstanding.size();
  end

endmodule

[tb/tb_top.sv]
// Testbench top of the trace predecoder: stimulus, run limit and verdict
`timescale 1ns / 1ps

module tb_top;
  import m6tp_pkg::*;

  localparam int ITEMS_TARGET = 1400;
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_op;
  logic [15:0] in_address;
  logic [7:0]  in_opcode;
  logic [7:0]  in_operand_low;
  logic [7:0]  in_operand_high;
  logic        out_valid;
  logic        out_hit;
  logic [7:0]  out_slot;
  logic [5:0]  out_uop_kind;
  logic [4:0]  out_addr_mode;
  logic [1:0]  out_instr_length;
  logic [15:0] out_operand_address;
  logic [7:0]  out_uop_data;
  logic        out_last_uop;
  logic [1:0]  out_error;

  int fails, pending, hit_count, close_count;
  int sent;
  int cycles;
  bit calm;                    // stretch with no gaps
  logic [15:0] addr_pool [16];
  logic [7:0]  closers [14] = '{8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hb0, 8'hd0,
                                8'hf0, 8'h4c, 8'h6c, 8'h20, 8'h60, 8'h40, 8'h00};

  mos6502_trace_predecoder i_dut (.*);

  mos6502_trace_predecoder_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic bit is_closer(input logic [7:0] o);
    foreach (closers[i]) if (closers[i] == o) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] plain_opcode();
    logic [7:0] o;
    do o = 8'($urandom_range(0, 255)); while (is_closer(o));
    return o;
  endfunction

  // called at a falling edge; returns at a falling edge once accepted and after any random gap
  task automatic issue(input logic op, input logic [15:0] addr, input logic [7:0] opc,
                       input logic [7:0] lo, input logic [7:0] hi);
    int gap;
    start           = 1'b1;
    in_op           = op;
    in_address      = addr;
    in_opcode       = opc;
    in_operand_low  = lo;
    in_operand_high = hi;
    do @(posedge clk); while (busy);
    @(negedge clk);
    // drop start so the same transaction is never taken twice
    start = 1'b0;
    sent++;
    if (sent % 100 == 0) calm = ($urandom_range(0, 3) == 0);
    gap = 0;
    if (!calm) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7, 8:    gap = $urandom_range(1, 3);
        default:       gap = $urandom_range(10, 40);
      endcase
    end
    if (gap > 0) begin
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic lookup(input logic [15:0] addr);
    issue(OP_LOOKUP, addr, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic decode(input logic [7:0] opc);
    issue(OP_DECODE, 16'($urandom), opc, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int n;
    start = 1'b0;
    in_op = OP_LOOKUP;
    in_address = '0;
    in_opcode = '0;
    in_operand_low = '0;
    in_operand_high = '0;
    rst_n = 1'b0;
    sent = 0;
    calm = 1'b0;
    foreach (addr_pool[i]) addr_pool[i] = 16'($urandom);
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: decode with nothing open, field extremes, special opcodes
    decode(8'hea);
    lookup(16'h0000);
    issue(OP_DECODE, 16'hffff, 8'hff, 8'hff, 8'hff);
    issue(OP_DECODE, 16'h0000, 8'h89, 8'h00, 8'h00);
    decode(8'h02);                 // unknown opcode still fills a place
    decode(8'h9a);
    decode(8'he9);
    decode(8'hca);
    decode(8'h00);                 // break closes the trace
    decode(8'ha9);                 // nothing open any more
    lookup(16'hffff);
    decode(8'h6c);
    lookup(16'h0000);              // hit, leaves no build open
    decode(8'h18);
    lookup(16'h8000);              // empty slot
    lookup(16'h0001);
    issue(OP_DECODE, 16'h5555, 8'h20, 8'h34, 8'h12);
    lookup(16'hffff);

    // wait until the block has drained
    while (pending != 0) @(negedge clk);

    // random traces, mostly well formed
    while (sent < ITEMS_TARGET) begin
      n = $urandom_range(0, 99);
      if (n < 70) begin
        if ($urandom_range(0, 2) == 0) lookup(addr_pool[$urandom_range(0, 15)]);
        else lookup(16'($urandom));
        repeat ($urandom_range(0, 5)) decode(plain_opcode());
        if ($urandom_range(0, 3) != 0) decode(closers[$urandom_range(0, 13)]);
      end else if (n < 74) begin
        // run up to the trace length limit
        lookup(16'($urandom));
        repeat ($urandom_range(31, 34)) decode(plain_opcode());
      end else if (n < 76) begin
        while (pending != 0) @(negedge clk);
      end else begin
        issue(1'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("%0d transactions sent, %0d lookup hits, %0d traces closed by a uop",
             sent, hit_count, close_count);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatching results", fails);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/m6tp_pkg.sv
rtl/core/m6tp_ctrl.sv
rtl/core/m6tp_dp.sv
rtl/core/mos6502_trace_predecoder.sv
tb/mos6502_trace_predecoder_checker.sv
tb/tb_top.sv
